[hdl/msps_pkg.sv]
`default_nettype none

package msps_pkg;

    // Longest sequence that the scan covers; later elements only set the flag.
    localparam int MAX_LEN = 256;

    // Field widths.
    localparam int VALUE_W = 8;
    localparam int PROD_W  = 64;
    localparam int INDEX_W = 8;

    // Internal index and counter widths follow from the sequence length.
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int POS_W = $clog2(MAX_LEN + 1);

    // Exact width of one product before saturation.
    localparam int EXT_W = PROD_W + VALUE_W;

    // Symmetric saturation limits.
    localparam logic signed [PROD_W-1:0] SAT_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = {1'b1, {(PROD_W-2){1'b0}}, 1'b1};
    localparam logic signed [EXT_W-1:0]  SAT_MAX_EXT = EXT_W'(SAT_MAX);
    localparam logic signed [EXT_W-1:0]  SAT_MIN_EXT = EXT_W'(SAT_MIN);

    // One saturated product with its overflow mark.
    typedef struct packed {
        logic signed [PROD_W-1:0] value;
        logic                     ovf;
    } msps_prod_t;

    // One result beat.
    typedef struct packed {
        logic signed [PROD_W-1:0] min_product;
        logic [INDEX_W-1:0]       first_index;
        logic [INDEX_W-1:0]       final_index;
        logic                     saturated;
    } msps_result_t;

    // Report an internal index modulo 2^INDEX_W.
    function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, idx};
        return wide[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/min_product_subarray_scan_core.sv]
`default_nettype none

// Minimum-product subarray scan. Each input beat carries one signed 8-bit
// element; tlast marks the final element of a sequence. After that element
// the block sends one result beat with the smallest product over all
// contiguous subarrays, the first and last index of that subarray (the
// earliest one on ties), and a flag in tuser that is set when any product
// saturated at +/-(2^63-1) or the sequence ran past MAX_LEN elements (only
// the first MAX_LEN take part in the scan). Elements are taken at one per
// cycle; a result goes to the output register when its last element
// advances out of the input register. The rate is set by the per-element
// recurrence: two 64x8 saturating multiplies and the compare-select of the
// running products are combinational. A last element waits in the input
// register only while the previous result is still unclaimed at the output.
module min_product_subarray_scan_core
    import msps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
    input  wire logic        s_axis_tlast,   // last

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [63:0] min_product, [71:64] first_index,
                                             // [79:72] final_index
    output logic             m_axis_tuser    // [0] saturated
);

    logic                      in_valid_reg;
    logic signed [VALUE_W-1:0] in_value_reg;
    logic                      in_last_reg;
    logic                      out_valid_reg;
    msps_result_t              out_data_reg;

    logic                      out_free;
    logic                      advance;
    logic                      in_take;
    msps_result_t              scan_result;

    // A non-final element never needs the output slot.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_value_reg <= $signed(s_axis_tdata[VALUE_W-1:0]);
            in_last_reg  <= s_axis_tlast;
        end
    end

    msps_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .value  (in_value_reg),
        .last   (in_last_reg),
        .result (scan_result)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= scan_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.final_index, out_data_reg.first_index,
                            out_data_reg.min_product};
    assign m_axis_tuser  = out_data_reg.saturated;

`ifndef ASSERT_OFF
    // A last element held behind an unclaimed result blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("min_product_subarray_scan_core: input open while result stalled");

    // A result appears only after a last element has advanced.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("min_product_subarray_scan_core: result without last element");

    // A stalled last element stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && !advance) |=> in_valid_reg && in_last_reg)
        else $error("min_product_subarray_scan_core: stalled last element lost");
`endif

endmodule

`default_nettype wire

[hdl/msps_sat_mul.sv]
`default_nettype none

module msps_sat_mul
    import msps_pkg::*;
(
    input  wire logic signed [PROD_W-1:0]  a,
    input  wire logic signed [VALUE_W-1:0] v,
    output msps_prod_t                     prod
);

    logic signed [EXT_W-1:0] exact;
    logic                    above;
    logic                    below;

    // Exact signed product of the running product and the element.
    assign exact = EXT_W'(a) * EXT_W'(v);

    // Clamp to the symmetric limits and mark the overflow.
    assign above = exact > SAT_MAX_EXT;
    assign below = exact < SAT_MIN_EXT;

    always_comb
    begin
        if (above)
        begin
            prod.value = SAT_MAX;
        end
        else if (below)
        begin
            prod.value = SAT_MIN;
        end
        else
        begin
            prod.value = exact[PROD_W-1:0];
        end
        prod.ovf = above | below;
    end

endmodule

`default_nettype wire

[hdl/msps_scan.sv]
`default_nettype none

module msps_scan
    import msps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      last,
    output msps_result_t                   result
);

    logic [POS_W-1:0]         pos_reg;
    logic signed [PROD_W-1:0] high_reg;
    logic signed [PROD_W-1:0] low_reg;
    logic [IDX_W-1:0]         high_start_reg;
    logic [IDX_W-1:0]         low_start_reg;
    logic signed [PROD_W-1:0] best_reg;
    logic [IDX_W-1:0]         best_first_reg;
    logic [IDX_W-1:0]         best_final_reg;
    logic                     ovf_reg;

    logic                     in_range;
    logic                     started;
    logic [IDX_W-1:0]         pos_idx;
    logic signed [PROD_W-1:0] elem;
    msps_prod_t               from_high;
    msps_prod_t               from_low;
    logic signed [PROD_W-1:0] high_next;
    logic signed [PROD_W-1:0] low_next;
    logic [IDX_W-1:0]         high_start_next;
    logic [IDX_W-1:0]         low_start_next;
    logic                     take_best;
    logic                     mul_ovf;

    assign in_range = pos_reg < POS_W'(MAX_LEN);
    assign started  = pos_reg != '0;
    assign pos_idx  = pos_reg[IDX_W-1:0];
    assign elem     = PROD_W'(value);

    // Extend both running products by the new element.
    msps_sat_mul u_mul_high (
        .a    (high_reg),
        .v    (value),
        .prod (from_high)
    );

    msps_sat_mul u_mul_low (
        .a    (low_reg),
        .v    (value),
        .prod (from_low)
    );

    // Pick the largest and smallest product ending here; on a tie the
    // earlier start wins. The element alone is the first candidate.
    always_comb
    begin
        high_next       = elem;
        low_next        = elem;
        high_start_next = pos_idx;
        low_start_next  = pos_idx;
        if (started)
        begin
            if ((from_high.value > high_next) ||
                ((from_high.value == high_next) && (high_start_reg < high_start_next)))
            begin
                high_next       = from_high.value;
                high_start_next = high_start_reg;
            end
            if ((from_high.value < low_next) ||
                ((from_high.value == low_next) && (high_start_reg < low_start_next)))
            begin
                low_next       = from_high.value;
                low_start_next = high_start_reg;
            end
            if ((from_low.value > high_next) ||
                ((from_low.value == high_next) && (low_start_reg < high_start_next)))
            begin
                high_next       = from_low.value;
                high_start_next = low_start_reg;
            end
            if ((from_low.value < low_next) ||
                ((from_low.value == low_next) && (low_start_reg < low_start_next)))
            begin
                low_next       = from_low.value;
                low_start_next = low_start_reg;
            end
        end
    end

    // Only a strictly smaller product replaces the best.
    assign take_best = in_range && (low_next < best_reg);
    assign mul_ovf   = in_range && started && (from_high.ovf || from_low.ovf);

    // Result as it stands after this element.
    always_comb
    begin
        if (take_best)
        begin
            result.min_product = low_next;
            result.first_index = to_index(low_start_next);
            result.final_index = to_index(pos_idx);
        end
        else
        begin
            result.min_product = best_reg;
            result.first_index = to_index(best_first_reg);
            result.final_index = to_index(best_final_reg);
        end
        result.saturated = ovf_reg || mul_ovf || !in_range;
    end

    // Scan state; the last element returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            high_start_reg <= '0;
            low_start_reg  <= '0;
            best_reg       <= SAT_MAX;
            best_first_reg <= '0;
            best_final_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                pos_reg        <= '0;
                high_reg       <= '0;
                low_reg        <= '0;
                high_start_reg <= '0;
                low_start_reg  <= '0;
                best_reg       <= SAT_MAX;
                best_first_reg <= '0;
                best_final_reg <= '0;
                ovf_reg        <= 1'b0;
            end
            else if (in_range)
            begin
                pos_reg        <= pos_reg + POS_W'(1);
                high_reg       <= high_next;
                low_reg        <= low_next;
                high_start_reg <= high_start_next;
                low_start_reg  <= low_start_next;
                if (take_best)
                begin
                    best_reg       <= low_next;
                    best_first_reg <= low_start_next;
                    best_final_reg <= pos_idx;
                end
                ovf_reg <= ovf_reg || mul_ovf;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    // The element counter never runs past the sequence limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("msps_scan: position beyond MAX_LEN");

    // Once a sequence has started, the largest ending product is never
    // below the smallest one.
    assert property (@(posedge clk) disable iff (!rst_n)
        started |-> (high_reg >= low_reg))
        else $error("msps_scan: high ending product below low ending product");

    // A final element leaves the scan in its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (pos_reg == '0) && (best_reg == SAT_MAX) && !ovf_reg)
        else $error("msps_scan: state not cleared after last element");

    // The best product is always within the saturation limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        best_reg >= SAT_MIN)
        else $error("msps_scan: best product outside saturation range");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb
    import msps_pkg::*;
();

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 150000;
    localparam int RANDOM_ELEMENTS = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] value
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // [63:0] min_product, [71:64] first_index,
                                 // [79:72] final_index
    logic        m_axis_tuser;   // [0] saturated

    // Scan state of the predictor.
    int                 scan_len;
    logic signed [63:0] top_run;
    logic signed [63:0] bottom_run;
    int                 top_from;
    int                 bottom_from;
    logic signed [63:0] best_prod;
    int                 best_from;
    int                 best_to;
    bit                 sat_seen;

    msps_result_t expected_results[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           steady;     // suppresses random idling on both sides
    bit           stalling;   // long receiver hold-off in progress
    event         hold_off_go;

    min_product_subarray_scan_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock.
    always #CLK_HALF clk = ~clk;

    // Run-time guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a quiet mode and the long hold-off.
    always @(negedge clk)
    begin
        if (stalling)
            m_axis_tready <= 1'b0;
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 7);
    end

    // Counts out the long hold-off on the result side.
    initial
    begin
        stalling = 1'b0;
        forever
        begin
            @(hold_off_go);
            @(posedge clk);
            stalling = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            stalling = 1'b0;
        end
    end

    // Result checker: each accepted beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        msps_result_t want;
        msps_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.min_product = m_axis_tdata[63:0];
            got.first_index = m_axis_tdata[71:64];
            got.final_index = m_axis_tdata[79:72];
            got.saturated   = m_axis_tuser;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result min=%0d first=%0d last=%0d sat=%0b",
                         $time, got.min_product, got.first_index, got.final_index,
                         got.saturated);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected min=%0d first=%0d last=%0d sat=%0b",
                             $time, want.min_product, want.first_index,
                             want.final_index, want.saturated);
                    $display("%0t:          actual   min=%0d first=%0d last=%0d sat=%0b",
                             $time, got.min_product, got.first_index,
                             got.final_index, got.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Product with symmetric saturation; any overflow marks the sequence.
    function automatic logic signed [63:0] sat_product(input logic signed [63:0] a,
                                                       input logic signed [7:0] v);
        logic signed [EXT_W-1:0] wide_a;
        logic signed [EXT_W-1:0] wide_v;
        logic signed [EXT_W-1:0] exact;
        wide_a = EXT_W'(a);
        wide_v = EXT_W'(v);
        exact  = wide_a * wide_v;
        if (exact > SAT_MAX_EXT)
        begin
            sat_seen = 1'b1;
            return SAT_MAX;
        end
        if (exact < SAT_MIN_EXT)
        begin
            sat_seen = 1'b1;
            return SAT_MIN;
        end
        return exact[63:0];
    endfunction

    function automatic void clear_scan();
        scan_len    = 0;
        top_run     = '0;
        bottom_run  = '0;
        top_from    = 0;
        bottom_from = 0;
        best_prod   = SAT_MAX;
        best_from   = 0;
        best_to     = 0;
        sat_seen    = 1'b0;
    endfunction

    // Advance the scan by one accepted element and queue the result on the last one.
    function automatic void scan_element(input logic signed [7:0] v, input logic is_last);
        logic signed [63:0] cand[2];
        int                 cand_from[2];
        logic signed [63:0] new_top;
        logic signed [63:0] new_bottom;
        int                 new_top_from;
        int                 new_bottom_from;
        msps_result_t       res;
        if (scan_len < MAX_LEN)
        begin
            new_top         = 64'(v);
            new_bottom      = 64'(v);
            new_top_from    = scan_len;
            new_bottom_from = scan_len;
            if (scan_len > 0)
            begin
                cand[0]      = sat_product(top_run, v);
                cand_from[0] = top_from;
                cand[1]      = sat_product(bottom_run, v);
                cand_from[1] = bottom_from;
                // On equal products the earlier start wins.
                for (int k = 0; k < 2; k++)
                begin
                    if (cand[k] > new_top || (cand[k] == new_top && cand_from[k] < new_top_from))
                    begin
                        new_top      = cand[k];
                        new_top_from = cand_from[k];
                    end
                    if (cand[k] < new_bottom ||
                        (cand[k] == new_bottom && cand_from[k] < new_bottom_from))
                    begin
                        new_bottom      = cand[k];
                        new_bottom_from = cand_from[k];
                    end
                end
            end
            top_run     = new_top;
            top_from    = new_top_from;
            bottom_run  = new_bottom;
            bottom_from = new_bottom_from;
            if (new_bottom < best_prod)
            begin
                best_prod = new_bottom;
                best_from = new_bottom_from;
                best_to   = scan_len;
            end
            scan_len++;
        end
        else
        begin
            // Elements past the length limit only mark the flag.
            sat_seen = 1'b1;
        end
        if (is_last)
        begin
            res.min_product = best_prod;
            res.first_index = best_from[7:0];
            res.final_index = best_to[7:0];
            res.saturated   = sat_seen;
            expected_results.push_back(res);
            clear_scan();
        end
    endfunction

    // Offer one element, idling at random first; returns at the falling edge after acceptance.
    task automatic send_element(input logic signed [7:0] v, input logic is_last);
        if (!steady)
        begin
            while ($urandom_range(99) < 7)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scan_element(v, is_last);
        @(negedge clk);
    endtask

    // Element values biased toward zeros and large magnitudes.
    function automatic logic signed [7:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 8'sd0;
        if (roll < 14)
            return -8'sd128;
        if (roll < 20)
            return 8'sd127;
        if (roll < 30)
            return 8'(int'($urandom_range(2)) - 1);
        return 8'($urandom_range(255));
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_element(pick_value(), i == len - 1);
    endtask

    // Sender pause: hold valid low until every expected result is back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Single-element sequences at the extremes, then short sequences with ties and sign changes.
    task automatic test_directed();
        send_element(8'sd127, 1'b1);
        send_element(-8'sd128, 1'b1);
        send_element(8'sd0, 1'b1);
        send_element(8'sd2, 1'b0);
        send_element(8'sd3, 1'b0);
        send_element(-8'sd4, 1'b1);
        send_element(-8'sd1, 1'b0);
        send_element(-8'sd1, 1'b0);
        send_element(-8'sd1, 1'b1);
        send_element(8'sd5, 1'b0);
        send_element(8'sd0, 1'b0);
        send_element(-8'sd3, 1'b0);
        send_element(8'sd0, 1'b0);
        send_element(-8'sd3, 1'b1);
        send_element(-8'sd2, 1'b0);
        send_element(-8'sd2, 1'b0);
        send_element(-8'sd2, 1'b1);
        send_element(8'sd1, 1'b0);
        send_element(-8'sd1, 1'b1);
        send_element(8'sd0, 1'b0);
        send_element(8'sd0, 1'b1);
        wait_for_results();
    endtask

    // Runs of the largest magnitudes drive the products into saturation.
    task automatic test_saturation();
        for (int i = 0; i < 12; i++)
            send_element(-8'sd128, i == 11);
        for (int i = 0; i < 12; i++)
            send_element(8'sd127, 1'b0);
        send_element(-8'sd1, 1'b1);
        for (int i = 0; i < 10; i++)
            send_element((i % 2 == 0) ? -8'sd128 : 8'sd127, i == 9);
        wait_for_results();
    endtask

    // Sequences at and beyond the length limit.
    task automatic test_length_limit();
        send_run(MAX_LEN);
        send_run(MAX_LEN + 3);
        wait_for_results();
    endtask

    // Random sequences, mostly short, some long enough to saturate.
    task automatic test_random_sequences();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ELEMENTS)
        begin
            len = ($urandom_range(99) < 80) ? $urandom_range(16, 1) : $urandom_range(40, 17);
            send_run(len);
            sent += len;
        end
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while short sequences keep coming.
    task automatic test_result_backpressure();
        -> hold_off_go;
        for (int i = 0; i < 40; i++)
            send_run($urandom_range(3, 1));
        wait_for_results();
    endtask

    // Back-to-back beats with no idling on either side.
    task automatic test_steady_stream();
        int sent;
        int len;
        steady <= 1'b1;
        sent = 0;
        while (sent < 150)
        begin
            len = $urandom_range(12, 1);
            send_run(len);
            sent += len;
        end
        steady <= 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        steady        = 1'b0;
        clear_scan();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_saturation();
        test_length_limit();
        test_random_sequences();
        test_result_backpressure();
        test_steady_stream();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
